// ===== hdl/cbs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared widths, types and the basis weight table for the cubic B-spline
// sampler.
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int SAMPLES     = 33;
  localparam int COORD_BITS  = 24;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_BITS    = $clog2(SAMPLES);
  localparam int PROD_BITS   = COORD_BITS + WEIGHT_BITS + 1;
  localparam int ACC_BITS    = PROD_BITS + 2;
  localparam int TAPS        = 4;

  localparam longint SPAN      = longint'(SAMPLES - 1);
  localparam longint BASIS_DEN = 6 * SPAN * SPAN * SPAN;
  localparam longint ONE_Q16   = 65536;
  localparam longint ROUND_HALF = 32768;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SAMPLES - 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [TAPS-1:0]            coord_quad_t;
  typedef logic [WEIGHT_BITS-1:0]       weight_t;
  typedef weight_t [TAPS-1:0]           weight_set_t;
  typedef weight_set_t [SAMPLES-1:0]    weight_table_t;
  typedef logic [IDX_BITS-1:0]          sample_idx_t;

  // sample request from the sequencer to the blend pipeline
  typedef struct packed {
    logic        valid;
    logic        last;
    sample_idx_t idx;
  } issue_t;

  // rounded basis weights; w2 takes the remainder so each set sums to one
  function automatic weight_table_t build_weights();
    weight_table_t tbl;
    longint t, r, n1, n3, n4, w1, w2, w3, w4;
    for (int j = 0; j < SAMPLES; j++) begin
      t  = longint'(j);
      r  = SPAN - t;
      n1 = r * r * r;
      n3 = 3 * t * t * SPAN + 3 * t * SPAN * SPAN + SPAN * SPAN * SPAN - 3 * t * t * t;
      n4 = t * t * t;
      w1 = (n1 * ONE_Q16 + BASIS_DEN / 2) / BASIS_DEN;
      w3 = (n3 * ONE_Q16 + BASIS_DEN / 2) / BASIS_DEN;
      w4 = (n4 * ONE_Q16 + BASIS_DEN / 2) / BASIS_DEN;
      w2 = ONE_Q16 - w1 - w3 - w4;
      tbl[j][0] = WEIGHT_BITS'(w1);
      tbl[j][1] = WEIGHT_BITS'(w2);
      tbl[j][2] = WEIGHT_BITS'(w3);
      tbl[j][3] = WEIGHT_BITS'(w4);
    end
    return tbl;
  endfunction

  localparam weight_table_t WEIGHT_TABLE = build_weights();

endpackage
`default_nettype wire

// ===== hdl/cbs_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_seq
// Control point window, segment latch and sample sequencer. A point that
// closes a segment latches four points and steps through every sample index.
// ----------------------------------------------------------------------------
module cbs_seq
  import cbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   point_valid,
  output logic        point_stall,
  input  wire coord_t point_x,
  input  wire coord_t point_y,
  input  wire logic   start_path,
  output issue_t      issue,
  output coord_quad_t seg_x,
  output coord_quad_t seg_y,
  input  wire logic   issue_ready
);

  coord_t      win_x [3];
  coord_t      win_y [3];
  logic [1:0]  seen;
  logic        active;
  sample_idx_t idx;
  logic        accept;
  logic        close;
  logic        fire;
  logic        fire_last;

  assign fire        = active && issue_ready;
  assign fire_last   = fire && (idx == LAST_IDX);
  assign point_stall = active && !fire_last;
  assign accept      = point_valid && !point_stall;
  assign close       = accept && !start_path && (seen == 2'd3);

  assign issue.valid = active;
  assign issue.last  = (idx == LAST_IDX);
  assign issue.idx   = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x  <= '{default: '0};
      win_y  <= '{default: '0};
      seen   <= '0;
      active <= 1'b0;
      idx    <= '0;
    end else begin
      if (close) begin
        // a new segment overrides the finishing one
        active <= 1'b1;
        idx    <= '0;
      end else if (fire) begin
        idx <= idx + 1'b1;
        if (fire_last) begin
          active <= 1'b0;
        end
      end
      if (accept) begin
        if (start_path) begin
          win_x[0] <= '0;
          win_x[1] <= '0;
          win_x[2] <= point_x;
          win_y[0] <= '0;
          win_y[1] <= '0;
          win_y[2] <= point_y;
          seen     <= 2'd1;
        end else begin
          if (seen != 2'd3) begin
            seen <= seen + 1'b1;
          end
          win_x[0] <= win_x[1];
          win_x[1] <= win_x[2];
          win_x[2] <= point_x;
          win_y[0] <= win_y[1];
          win_y[1] <= win_y[2];
          win_y[2] <= point_y;
        end
      end
    end
  end

  // segment latch, loaded only by a closing point
  always_ff @(posedge clk) begin
    if (close) begin
      seg_x <= {point_x, win_x[2], win_x[1], win_x[0]};
      seg_y <= {point_y, win_y[2], win_y[1], win_y[0]};
    end
  end

  a_close_starts: assert property (@(posedge clk) disable iff (rst)
    close |=> active && (idx == '0))
    else $error("closing point did not start a segment");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (idx <= LAST_IDX))
    else $error("sample index beyond last sample");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    fire_last && !accept |=> !active)
    else $error("segment did not finish after last sample");

endmodule
`default_nettype wire

// ===== hdl/cbs_blend.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbs_blend
// Two-stage blend: weight lookup and products, then sum, rounding and the
// result register.
// ----------------------------------------------------------------------------
module cbs_blend
  import cbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire issue_t      issue,
  input  wire coord_quad_t seg_x,
  input  wire coord_quad_t seg_y,
  output logic             issue_ready,
  output logic             curve_valid,
  input  wire logic        curve_stall,
  output coord_t           curve_x,
  output coord_t           curve_y,
  output logic             segment_end
);

  logic                        a_valid;
  logic                        a_last;
  logic signed [PROD_BITS-1:0] prod_x [TAPS];
  logic signed [PROD_BITS-1:0] prod_y [TAPS];
  logic                        b_ready;
  logic                        a_ready;
  weight_set_t                 w;
  logic signed [ACC_BITS-1:0]  sum_x;
  logic signed [ACC_BITS-1:0]  sum_y;
  logic signed [ACC_BITS-1:0]  rnd_x;
  logic signed [ACC_BITS-1:0]  rnd_y;

  assign b_ready     = !curve_valid || !curve_stall;
  assign a_ready     = !a_valid || b_ready;
  assign issue_ready = a_ready;
  assign w           = WEIGHT_TABLE[issue.idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= issue.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && issue.valid) begin
      a_last <= issue.last;
      for (int k = 0; k < TAPS; k++) begin
        prod_x[k] <= $signed({1'b0, w[k]}) * $signed(seg_x[k]);
        prod_y[k] <= $signed({1'b0, w[k]}) * $signed(seg_y[k]);
      end
    end
  end

  always_comb begin
    sum_x = ACC_BITS'(prod_x[0]) + ACC_BITS'(prod_x[1])
          + ACC_BITS'(prod_x[2]) + ACC_BITS'(prod_x[3]);
    sum_y = ACC_BITS'(prod_y[0]) + ACC_BITS'(prod_y[1])
          + ACC_BITS'(prod_y[2]) + ACC_BITS'(prod_y[3]);
    // round half up, then drop the sixteen weight fraction bits
    rnd_x = sum_x + ACC_BITS'(ROUND_HALF);
    rnd_y = sum_y + ACC_BITS'(ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_valid <= 1'b0;
    end else if (b_ready) begin
      curve_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      curve_x     <= rnd_x[WEIGHT_BITS +: COORD_BITS];
      curve_y     <= rnd_y[WEIGHT_BITS +: COORD_BITS];
      segment_end <= a_last;
    end
  end

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_ready |=> a_valid && $stable(a_last) && $stable(prod_x[0]))
    else $error("product stage lost data under stall");

  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    !curve_valid |-> issue_ready)
    else $error("pipeline blocked with empty output");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(curve_valid) |-> $past(a_valid))
    else $error("result without product stage beat");

endmodule
`default_nettype wire

// ===== hdl/cubic_bspline_sampler.sv =====
`default_nettype none
// The first sample of a segment passes the segment latch, the product stage and the
// result register before it reaches the outputs; later samples follow in index order.
// Throughput: one sample per cycle while curve_stall is low; a closing point holds
// the sequencer until its last sample index issues, and any point waits meanwhile.
// Reset clears the point window, the point count and all pipeline valids.
// ----------------------------------------------------------------------------
// cubic_bspline_sampler
// Uniform cubic B-spline evaluation on a stream of 2D control points.
// ----------------------------------------------------------------------------
module cubic_bspline_sampler
  import cbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   point_valid,
  output logic        point_stall,
  input  wire coord_t point_x,
  input  wire coord_t point_y,
  input  wire logic   start_path,
  output logic        curve_valid,
  input  wire logic   curve_stall,
  output coord_t      curve_x,
  output coord_t      curve_y,
  output logic        segment_end
);

  issue_t      issue;
  coord_quad_t seg_x;
  coord_quad_t seg_y;
  logic        issue_ready;

  cbs_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .start_path  (start_path),
    .issue       (issue),
    .seg_x       (seg_x),
    .seg_y       (seg_y),
    .issue_ready (issue_ready)
  );

  cbs_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .seg_x       (seg_x),
    .seg_y       (seg_y),
    .issue_ready (issue_ready),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .segment_end (segment_end)
  );

endmodule
`default_nettype wire
